@@ rtl/qrs_pkg.sv @@
package qrs_pkg;

  localparam int DW         = 32;
  localparam int TOL_W      = 16;
  localparam int SQ_CELLS   = 34;
  localparam int SQ_ROOT_W  = 34;
  localparam int SQ_REM_W   = 66;
  localparam int SQ_TRIAL_W = 68;
  localparam int DV_CELLS   = 51;
  localparam int DV_NUM_W   = 51;
  localparam int DV_DEN_W   = 33;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INF,
    KIND_LIN,
    KIND_ONE,
    KIND_TWO
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic signed [DW-1:0]  a;
    logic signed [DW-1:0]  b;
    logic signed [DW-1:0]  c;
  } sq_ctx_t;

  typedef struct packed {
    kind_t kind;
    logic  neg_x;
    logic  neg_y;
  } dv_ctx_t;

endpackage

@@ rtl/qrs_sqrt_cell.sv @@
module qrs_sqrt_cell import qrs_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [SQ_REM_W-1:0]   in_rem,
  input  logic [SQ_ROOT_W-1:0]  in_root,
  input  sq_ctx_t               in_ctx,
  output logic                  out_valid,
  output logic [SQ_REM_W-1:0]   out_rem,
  output logic [SQ_ROOT_W-1:0]  out_root,
  output sq_ctx_t               out_ctx
);

  logic                  valid_r;
  logic [SQ_REM_W-1:0]   rem_r, rem_nxt;
  logic [SQ_ROOT_W-1:0]  root_r, root_nxt;
  sq_ctx_t               ctx_r;
  logic [SQ_TRIAL_W-1:0] trial;
  logic                  take;

  // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
  always_comb begin
    trial    = (SQ_TRIAL_W'(in_root) << (BIT + 1)) | (SQ_TRIAL_W'(1) << (2 * BIT));
    take     = trial <= SQ_TRIAL_W'(in_rem);
    rem_nxt  = take ? SQ_REM_W'(SQ_TRIAL_W'(in_rem) - trial) : in_rem;
    root_nxt = take ? (in_root | (SQ_ROOT_W'(1) << BIT)) : in_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    ctx_r  <= in_ctx;
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_ctx   = ctx_r;

endmodule

@@ rtl/qrs_div_cell.sv @@
module qrs_div_cell import qrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [DV_DEN_W-1:0]  in_den,
  input  logic [DV_NUM_W-1:0]  in_nq_x,
  input  logic [DV_DEN_W-1:0]  in_rem_x,
  input  logic [DV_NUM_W-1:0]  in_nq_y,
  input  logic [DV_DEN_W-1:0]  in_rem_y,
  input  dv_ctx_t              in_ctx,
  output logic                 out_valid,
  output logic [DV_DEN_W-1:0]  out_den,
  output logic [DV_NUM_W-1:0]  out_nq_x,
  output logic [DV_DEN_W-1:0]  out_rem_x,
  output logic [DV_NUM_W-1:0]  out_nq_y,
  output logic [DV_DEN_W-1:0]  out_rem_y,
  output dv_ctx_t              out_ctx
);

  logic                 valid_r;
  logic [DV_DEN_W-1:0]  den_r;
  logic [DV_NUM_W-1:0]  nq_x_r, nq_x_nxt, nq_y_r, nq_y_nxt;
  logic [DV_DEN_W-1:0]  rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  dv_ctx_t              ctx_r;
  logic [DV_DEN_W:0]    den_ext, tx, ty;
  logic                 gx, gy;

  // bring down the next numerator bit; quotient bits shift in from the bottom
  always_comb begin
    den_ext   = {1'b0, in_den};
    tx        = {in_rem_x, in_nq_x[DV_NUM_W-1]};
    ty        = {in_rem_y, in_nq_y[DV_NUM_W-1]};
    gx        = tx >= den_ext;
    gy        = ty >= den_ext;
    rem_x_nxt = gx ? DV_DEN_W'(tx - den_ext) : tx[DV_DEN_W-1:0];
    rem_y_nxt = gy ? DV_DEN_W'(ty - den_ext) : ty[DV_DEN_W-1:0];
    nq_x_nxt  = {in_nq_x[DV_NUM_W-2:0], gx};
    nq_y_nxt  = {in_nq_y[DV_NUM_W-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    den_r   <= in_den;
    nq_x_r  <= nq_x_nxt;
    nq_y_r  <= nq_y_nxt;
    rem_x_r <= rem_x_nxt;
    rem_y_r <= rem_y_nxt;
    ctx_r   <= in_ctx;
  end

  assign out_valid = valid_r;
  assign out_den   = den_r;
  assign out_nq_x  = nq_x_r;
  assign out_rem_x = rem_x_r;
  assign out_nq_y  = nq_y_r;
  assign out_rem_y = rem_y_r;
  assign out_ctx   = ctx_r;

endmodule

@@ rtl/quadratic_root_solver_unit.sv @@
// Quadratic root solver: one coefficient set a, b, c (signed Q16.16) is taken
// in every clock cycle, and busy stays low. Each result shows on the out_ ports
// for a single cycle, marked by out_valid; the receiver must take it then, as
// nothing holds it. Results leave in the order the words came in. The
// pipeline is the row of 34 square-root cells (one root bit each) followed
// by 51 divider cells (one quotient bit each, both roots side by side), plus
// nine setup and finishing stages. Write cfg_write_data to the tolerance only
// while no word is in flight.
module quadratic_root_solver_unit import qrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [DW-1:0] in_coef_a,
  input  logic signed [DW-1:0] in_coef_b,
  input  logic signed [DW-1:0] in_coef_c,
  output logic                 out_valid,
  output logic [1:0]           out_root_count,
  output logic signed [DW-1:0] out_root_low,
  output logic signed [DW-1:0] out_root_high,
  output logic                 out_saturated,
  input  logic                 cfg_write_en,
  input  logic [TOL_W-1:0]     cfg_write_data
);

  localparam logic [DV_NUM_W-1:0] Q_NEG_LIM = DV_NUM_W'(33'h0_8000_0000);
  localparam logic [DV_NUM_W-1:0] Q_POS_LIM = DV_NUM_W'(33'h0_7FFF_FFFF);

  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_W'(1);
    end else if (cfg_write_en) begin
      tol_r <= cfg_write_data;
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 0: capture
  logic                 v0_r;
  logic signed [DW-1:0] a0_r, b0_r, c0_r;

  // ---------------- stage 1: magnitudes, near-zero tests, products
  logic [DW-1:0]        ma1, mb1, mc1;
  logic                 v1_r, nza1_r, nzb1_r, nzc1_r;
  logic signed [DW-1:0] a1_r, b1_r, c1_r;
  logic [2*DW-1:0]      bb1_r, p1_r;

  // ---------------- stage 2: discriminant
  logic [SQ_REM_W-1:0]  four_p, d2;
  logic [SQ_REM_W:0]    diff2;
  logic                 neg2;
  logic                 v2_r, nza2_r, nzb2_r, nzc2_r, neg2_r;
  logic signed [DW-1:0] a2_r, b2_r, c2_r;
  logic [SQ_REM_W-1:0]  d2_r;

  // ---------------- stage 3: classify
  logic [SQ_REM_W-1:0]  thr3;
  kind_t                kind3;
  logic                 v3_r;
  sq_ctx_t              ctx3_r;
  logic [SQ_REM_W-1:0]  d3_r;

  always_comb begin
    ma1 = a0_r[DW-1] ? DW'(-a0_r) : DW'(a0_r);
    mb1 = b0_r[DW-1] ? DW'(-b0_r) : DW'(b0_r);
    mc1 = c0_r[DW-1] ? DW'(-c0_r) : DW'(c0_r);
  end

  always_comb begin
    four_p = {p1_r, 2'b00};
    diff2  = {3'b000, bb1_r} - {1'b0, four_p};
    if (a1_r[DW-1] != c1_r[DW-1]) begin
      d2   = {2'b00, bb1_r} + four_p;
      neg2 = 1'b0;
    end else begin
      d2   = diff2[SQ_REM_W-1:0];
      neg2 = diff2[SQ_REM_W];
    end
  end

  always_comb begin
    thr3 = SQ_REM_W'({tol_r, 16'h0000});
    if (nza2_r) begin
      if (nzb2_r) begin
        kind3 = nzc2_r ? KIND_INF : KIND_NONE;
      end else begin
        kind3 = KIND_LIN;
      end
    end else if (neg2_r) begin
      kind3 = KIND_NONE;
    end else if (d2_r == '0 || d2_r < thr3) begin
      kind3 = KIND_ONE;
    end else begin
      kind3 = KIND_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= start;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    a0_r   <= in_coef_a;
    b0_r   <= in_coef_b;
    c0_r   <= in_coef_c;
    a1_r   <= a0_r;
    b1_r   <= b0_r;
    c1_r   <= c0_r;
    nza1_r <= (a0_r == '0) || (ma1 < DW'(tol_r));
    nzb1_r <= (b0_r == '0) || (mb1 < DW'(tol_r));
    nzc1_r <= (c0_r == '0) || (mc1 < DW'(tol_r));
    bb1_r  <= mb1 * mb1;
    p1_r   <= ma1 * mc1;
    a2_r   <= a1_r;
    b2_r   <= b1_r;
    c2_r   <= c1_r;
    nza2_r <= nza1_r;
    nzb2_r <= nzb1_r;
    nzc2_r <= nzc1_r;
    d2_r   <= d2;
    neg2_r <= neg2;
    ctx3_r <= '{kind: kind3, a: a2_r, b: b2_r, c: c2_r};
    d3_r   <= d2_r;
  end

  // ---------------- square-root cells
  logic                 sq_v    [SQ_CELLS+1];
  logic [SQ_REM_W-1:0]  sq_rem  [SQ_CELLS+1];
  logic [SQ_ROOT_W-1:0] sq_root [SQ_CELLS+1];
  sq_ctx_t              sq_ctx  [SQ_CELLS+1];

  assign sq_v[0]    = v3_r;
  assign sq_rem[0]  = d3_r;
  assign sq_root[0] = '0;
  assign sq_ctx[0]  = ctx3_r;

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
    qrs_sqrt_cell #(.BIT(SQ_CELLS - 1 - k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (sq_v[k]),
      .in_rem   (sq_rem[k]),
      .in_root  (sq_root[k]),
      .in_ctx   (sq_ctx[k]),
      .out_valid(sq_v[k+1]),
      .out_rem  (sq_rem[k+1]),
      .out_root (sq_root[k+1]),
      .out_ctx  (sq_ctx[k+1])
    );
  end

  // ---------------- stage 4: numerators and divisor
  sq_ctx_t            sctx;
  logic signed [35:0] b36, c36, s36, nx36, ny36;
  logic signed [33:0] a34, b34, den4;
  logic               v4_r;
  kind_t              kind4_r;
  logic signed [51:0] nx4_r, ny4_r;
  logic signed [33:0] den4_r;

  always_comb begin
    sctx = sq_ctx[SQ_CELLS];
    b36  = {{4{sctx.b[DW-1]}}, sctx.b};
    c36  = {{4{sctx.c[DW-1]}}, sctx.c};
    s36  = {2'b00, sq_root[SQ_CELLS]};
    a34  = {{2{sctx.a[DW-1]}}, sctx.a};
    b34  = {{2{sctx.b[DW-1]}}, sctx.b};
    case (sctx.kind)
      KIND_LIN: begin
        nx36 = -c36;
        ny36 = -c36;
        den4 = b34;
      end
      KIND_TWO: begin
        nx36 = s36 - b36;
        ny36 = -b36 - s36;
        den4 = a34 <<< 1;
      end
      default: begin
        nx36 = -b36;
        ny36 = -b36;
        den4 = a34 <<< 1;
      end
    endcase
  end

  // ---------------- stage 5: magnitudes and quotient signs
  logic [51:0]         anx5, any5;
  logic [33:0]         aden5;
  logic                v5_r;
  dv_ctx_t             ctx5_r;
  logic [DV_NUM_W-1:0] unx5_r, uny5_r;
  logic [DV_DEN_W-1:0] ud5_r;

  always_comb begin
    anx5  = nx4_r[51] ? 52'(-nx4_r) : 52'(nx4_r);
    any5  = ny4_r[51] ? 52'(-ny4_r) : 52'(ny4_r);
    aden5 = den4_r[33] ? 34'(-den4_r) : 34'(den4_r);
  end

  // ---------------- stage 6: add half the divisor for rounding
  logic                v6_r;
  dv_ctx_t             ctx6_r;
  logic [DV_NUM_W-1:0] nqx6_r, nqy6_r;
  logic [DV_DEN_W-1:0] den6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      v4_r <= sq_v[SQ_CELLS];
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
    kind4_r <= sctx.kind;
    nx4_r   <= {nx36, 16'h0000};
    ny4_r   <= {ny36, 16'h0000};
    den4_r  <= den4;
    ctx5_r  <= '{kind: kind4_r, neg_x: nx4_r[51] ^ den4_r[33],
                 neg_y: ny4_r[51] ^ den4_r[33]};
    unx5_r  <= anx5[DV_NUM_W-1:0];
    uny5_r  <= any5[DV_NUM_W-1:0];
    ud5_r   <= aden5[DV_DEN_W-1:0];
    ctx6_r  <= ctx5_r;
    nqx6_r  <= unx5_r + DV_NUM_W'(ud5_r >> 1);
    nqy6_r  <= uny5_r + DV_NUM_W'(ud5_r >> 1);
    den6_r  <= ud5_r;
  end

  // ---------------- divider cells
  logic                dv_v    [DV_CELLS+1];
  logic [DV_DEN_W-1:0] dv_den  [DV_CELLS+1];
  logic [DV_NUM_W-1:0] dv_nq_x [DV_CELLS+1];
  logic [DV_DEN_W-1:0] dv_rm_x [DV_CELLS+1];
  logic [DV_NUM_W-1:0] dv_nq_y [DV_CELLS+1];
  logic [DV_DEN_W-1:0] dv_rm_y [DV_CELLS+1];
  dv_ctx_t             dv_ctx  [DV_CELLS+1];

  assign dv_v[0]    = v6_r;
  assign dv_den[0]  = den6_r;
  assign dv_nq_x[0] = nqx6_r;
  assign dv_rm_x[0] = '0;
  assign dv_nq_y[0] = nqy6_r;
  assign dv_rm_y[0] = '0;
  assign dv_ctx[0]  = ctx6_r;

  for (genvar k = 0; k < DV_CELLS; k++) begin : g_dv
    qrs_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dv_v[k]),
      .in_den   (dv_den[k]),
      .in_nq_x  (dv_nq_x[k]),
      .in_rem_x (dv_rm_x[k]),
      .in_nq_y  (dv_nq_y[k]),
      .in_rem_y (dv_rm_y[k]),
      .in_ctx   (dv_ctx[k]),
      .out_valid(dv_v[k+1]),
      .out_den  (dv_den[k+1]),
      .out_nq_x (dv_nq_x[k+1]),
      .out_rem_x(dv_rm_x[k+1]),
      .out_nq_y (dv_nq_y[k+1]),
      .out_rem_y(dv_rm_y[k+1]),
      .out_ctx  (dv_ctx[k+1])
    );
  end

  // ---------------- stage 7: sign and clamp
  dv_ctx_t             dctx;
  logic [DV_NUM_W-1:0] qx, qy;
  logic signed [DW-1:0] rx7, ry7;
  logic                sx7, sy7;
  logic                v7_r, satx7_r, saty7_r;
  kind_t               kind7_r;
  logic signed [DW-1:0] rx7_r, ry7_r;

  always_comb begin
    dctx = dv_ctx[DV_CELLS];
    qx   = dv_nq_x[DV_CELLS];
    qy   = dv_nq_y[DV_CELLS];
    if (dctx.neg_x) begin
      sx7 = qx > Q_NEG_LIM;
      rx7 = sx7 ? {1'b1, {(DW-1){1'b0}}} : DW'(-qx);
    end else begin
      sx7 = qx > Q_POS_LIM;
      rx7 = sx7 ? {1'b0, {(DW-1){1'b1}}} : qx[DW-1:0];
    end
    if (dctx.neg_y) begin
      sy7 = qy > Q_NEG_LIM;
      ry7 = sy7 ? {1'b1, {(DW-1){1'b0}}} : DW'(-qy);
    end else begin
      sy7 = qy > Q_POS_LIM;
      ry7 = sy7 ? {1'b0, {(DW-1){1'b1}}} : qy[DW-1:0];
    end
  end

  // ---------------- stage 8: order, snap to zero, output word
  logic signed [DW-1:0] lo8, hi8, lo8s, hi8s;
  logic [DW-1:0]        mlo8, mhi8;
  logic [1:0]           cnt8;
  logic                 sat8;
  logic                 out_valid_r, out_sat_r;
  logic [1:0]           out_cnt_r;
  logic signed [DW-1:0] out_lo_r, out_hi_r;

  always_comb begin
    lo8  = (rx7_r < ry7_r) ? rx7_r : ry7_r;
    hi8  = (rx7_r < ry7_r) ? ry7_r : rx7_r;
    cnt8 = CNT_NONE;
    sat8 = 1'b0;
    case (kind7_r)
      KIND_INF: begin
        cnt8 = CNT_INF;
        lo8  = '0;
        hi8  = '0;
      end
      KIND_LIN, KIND_ONE: begin
        cnt8 = CNT_ONE;
        lo8  = rx7_r;
        hi8  = rx7_r;
        sat8 = satx7_r;
      end
      KIND_TWO: begin
        cnt8 = CNT_TWO;
        sat8 = satx7_r | saty7_r;
      end
      default: begin
        lo8 = '0;
        hi8 = '0;
      end
    endcase
    mlo8 = lo8[DW-1] ? DW'(-lo8) : DW'(lo8);
    mhi8 = hi8[DW-1] ? DW'(-hi8) : DW'(hi8);
    lo8s = (mlo8 < DW'(tol_r)) ? '0 : lo8;
    hi8s = (mhi8 < DW'(tol_r)) ? '0 : hi8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v7_r        <= dv_v[DV_CELLS];
      out_valid_r <= v7_r;
    end
    kind7_r   <= dctx.kind;
    rx7_r     <= rx7;
    ry7_r     <= ry7;
    satx7_r   <= sx7;
    saty7_r   <= sy7;
    out_cnt_r <= cnt8;
    out_lo_r  <= lo8s;
    out_hi_r  <= hi8s;
    out_sat_r <= sat8;
  end

  assign out_valid      = out_valid_r;
  assign out_root_count = out_cnt_r;
  assign out_root_low   = out_lo_r;
  assign out_root_high  = out_hi_r;
  assign out_saturated  = out_sat_r;

  a_no_root_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_root_count == CNT_NONE || out_root_count == CNT_INF)
    |-> out_root_low == '0 && out_root_high == '0 && !out_saturated)
    else $error("root fields set without roots");

  a_one_root_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count == CNT_ONE |-> out_root_low == out_root_high)
    else $error("single root fields differ");

  a_two_roots_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count == CNT_TWO |-> out_root_low <= out_root_high)
    else $error("roots out of order");

  a_valid_follows_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r |=> out_valid)
    else $error("result word dropped at output stage");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import qrs_pkg::*;

  class root_scoreboard;
    logic [1:0]           cnt_q[$];
    logic signed [DW-1:0] lo_q[$];
    logic signed [DW-1:0] hi_q[$];
    logic                 sat_q[$];
    int                   mismatches;
    logic [TOL_W-1:0]     tol;

    function new();
      mismatches = 0;
      tol = 1;
    endfunction

    function bit is_near(longint x);
      longint m;
      m = (x < 0) ? -x : x;
      return (x == 0) || (m < longint'(tol));
    endfunction

    // round to nearest, ties away from zero; 128-bit to hold (-b +- s) * 2^16
    function logic signed [127:0] round_div(logic signed [127:0] n, logic signed [127:0] d);
      logic [127:0] un, ud, q;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un + ud / 2) / ud;
      return ((n < 0) != (d < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function logic signed [127:0] clamp(logic signed [127:0] v, inout logic sat);
      if (v > 128'sd2147483647) begin
        sat = 1'b1;
        return 128'sd2147483647;
      end
      if (v < -128'sd2147483648) begin
        sat = 1'b1;
        return -128'sd2147483648;
      end
      return v;
    endfunction

    function logic signed [127:0] snap(logic signed [127:0] v);
      logic [127:0] m;
      m = (v < 0) ? -v : v;
      return (m < tol) ? 128'sd0 : v;
    endfunction

    function logic [127:0] isqrt(logic [127:0] d);
      logic [127:0] r, cand;
      r = 0;
      for (int i = 33; i >= 0; i--) begin
        cand = r | (128'd1 << i);
        if (cand * cand <= d) r = cand;
      end
      return r;
    endfunction

    function void note_equation(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                                logic signed [DW-1:0] c);
      logic signed [127:0] sa, sb, sc, disc, r1, r2, x, y, s;
      logic [1:0] cnt;
      logic sat;
      sa = a; sb = b; sc = c;
      cnt = CNT_NONE; r1 = 0; r2 = 0; sat = 1'b0;
      if (is_near(a)) begin
        if (is_near(b)) begin
          cnt = is_near(c) ? CNT_INF : CNT_NONE;
        end else begin
          r1 = clamp(round_div(-sc * 65536, sb), sat);
          r2 = r1;
          cnt = CNT_ONE;
        end
      end else begin
        disc = sb * sb - 4 * sa * sc;
        if (disc >= 0) begin
          // an exactly zero discriminant is one root even with zero tolerance
          if (disc == 0 || disc < (128'sd1 * tol) * 65536) begin
            r1 = clamp(round_div(-sb * 65536, 2 * sa), sat);
            r2 = r1;
            cnt = CNT_ONE;
          end else begin
            s = $signed(isqrt(disc));
            x = clamp(round_div((-sb + s) * 65536, 2 * sa), sat);
            y = clamp(round_div((-sb - s) * 65536, 2 * sa), sat);
            r1 = (x < y) ? x : y;
            r2 = (x < y) ? y : x;
            cnt = CNT_TWO;
          end
        end
      end
      cnt_q.push_back(cnt);
      lo_q.push_back(snap(r1));
      hi_q.push_back(snap(r2));
      sat_q.push_back(sat);
    endfunction

    function void check_roots(logic [1:0] cnt, logic signed [DW-1:0] lo,
                              logic signed [DW-1:0] hi, logic sat);
      logic [1:0] ec;
      logic signed [DW-1:0] el, eh;
      logic es;
      if (cnt_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: count %0d lo %0d hi %0d", cnt, lo, hi);
        return;
      end
      ec = cnt_q.pop_front(); el = lo_q.pop_front();
      eh = hi_q.pop_front(); es = sat_q.pop_front();
      if (cnt !== ec || lo !== el || hi !== eh || sat !== es) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp cnt %0d lo %0d hi %0d sat %0b, got cnt %0d lo %0d hi %0d sat %0b",
                   ec, el, eh, es, cnt, lo, hi, sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [DW-1:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic out_valid;
  logic [1:0] out_root_count;
  logic signed [DW-1:0] out_root_low, out_root_high;
  logic out_saturated;
  logic cfg_write_en = 1'b0;
  logic [TOL_W-1:0] cfg_write_data = '0;

  root_scoreboard sb = new();
  int sender_idle_pct;
  longint cycles;

  always #4 clk = ~clk;

  quadratic_root_solver_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_root_count(out_root_count),
    .out_root_low(out_root_low), .out_root_high(out_root_high),
    .out_saturated(out_saturated),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_roots(out_root_count, out_root_low, out_root_high, out_saturated);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end
  initial cycles = 0;

  // offer one word; hold start until it is taken
  task automatic send_word(logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                           logic signed [DW-1:0] c);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_coef_a <= a; in_coef_b <= b; in_coef_c <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_equation(a, b, c);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.cnt_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_tolerance(logic [TOL_W-1:0] t);
    cfg_write_en <= 1'b1;
    cfg_write_data <= t;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.tol = t;
  endtask

  function automatic logic signed [DW-1:0] pick_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(200)) - 100;
      2: return ($signed($urandom_range(40)) - 20) <<< 16;
      3: return $signed($urandom_range(4000)) - 2000;
      4: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  initial begin
    logic [TOL_W-1:0] tols[5];
    int pcts[4];
    logic signed [DW-1:0] k;
    tols = '{16'd0, 16'd65535, 16'd1, 16'd300, 16'd7};
    pcts = '{0, 69, 0, 36};
    sender_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate a, zero discriminant, complex, two roots, extremes
    send_word(0, 0, 0);
    send_word(0, 0, 32'sh10000);
    send_word(0, 32'sh20000, 32'sh40000);
    send_word(0, 1, 32'sh7fffffff);
    send_word(32'sh10000, 32'sh20000, 32'sh10000);
    send_word(32'sh10000, 0, 32'sh10000);
    send_word(32'sh10000, 0, -32'sh40000);
    send_word(-32'sh10000, 32'sh30000, 32'sh40000);
    send_word(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    send_word(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_word(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    send_word(1, 32'sh80000000, 1);
    send_word(1, 0, -1);
    send_word(32'sh10000, 32'sh10000, 0);
    send_word(32'shffffffff, 32'shffffffff, 32'shffffffff);
    send_word(32'sh55555555, 32'shaaaaaaaa, 32'sh12345678);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      set_tolerance(tols[ph]);
      for (int n = 0; n < 130; n++) begin
        sender_idle_pct = pcts[(n / 33) % 4];
        if ($urandom_range(3) == 0) begin
          // build from a chosen double root so the one-root path is hit often
          k = ($signed($urandom_range(20)) - 10) <<< 16;
          send_word(32'sh10000, -2 * k, (k >>> 16) * k);
        end else begin
          send_word(pick_coef(), pick_coef(), pick_coef());
        end
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.cnt_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/qrs_pkg.sv
rtl/qrs_sqrt_cell.sv
rtl/qrs_div_cell.sv
rtl/quadratic_root_solver_unit.sv
tb/tb_top.sv
